FILE: hdl/srg_pkg.sv
// ----------------------------------------------------------------------------
// srg_pkg
// Shared types and constants for the setpoint ramp generator: command codes,
// divider operand selects and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package srg_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned RateW = 15;
  localparam int unsigned DurW  = 16;
  localparam int unsigned FuncW = 2;
  localparam int unsigned ProdW = DurW + RateW;

  localparam logic [RateW-1:0] RATE_RESET   = RateW'(1000);
  localparam logic [DataW-1:0] RATE_DIVISOR = DataW'(1000);

  // divide by 1000 as a shift by 3 then a reciprocal multiply for 125,
  // exact for every product of a duration and a rate
  localparam int unsigned RecipPreShift = 3;
  localparam int unsigned RecipPreW     = ProdW - RecipPreShift;
  localparam int unsigned RecipMulW     = 29;
  localparam int unsigned RecipProdW    = RecipPreW + RecipMulW;
  localparam int unsigned RecipShift    = 35;
  localparam int unsigned RecipOutW     = RecipProdW - RecipShift;
  localparam logic [RecipMulW-1:0] RECIP_MUL = RecipMulW'(274877907);

  typedef enum logic [FuncW-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_TIMED = 2'd1,
    FUNC_STEP  = 2'd2,
    FUNC_STOP  = 2'd3
  } func_t;

  typedef enum logic {
    DIV_SLOPE = 1'b0,
    DIV_STEP  = 1'b1
  } div_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     tick;
    logic     jump;
    logic     stop;
    logic     mul;
    logic     recip;
    logic     div_start;
    div_sel_t div_sel;
    logic     set_n;
    logic     set_slope;
    logic     set_step;
    logic     out_load;
  } srg_cmd_t;

  typedef struct packed {
    func_t func;
    logic  dur_zero;
    logic  inc_zero;
    logic  div_done;
    logic  n_zero;
    logic  out_free;
  } srg_status_t;

endpackage

FILE: hdl/srg_div.sv
// ----------------------------------------------------------------------------
// srg_div
// Iterative signed 32-bit divider, truncating toward zero. Restoring
// algorithm on magnitudes, one quotient bit per cycle, sign fixed at the end.
// ----------------------------------------------------------------------------
module srg_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [srg_pkg::DataW-1:0] dividend,
  input  logic [srg_pkg::DataW-1:0] divisor,
  output logic                      busy,
  output logic                      done,
  output logic [srg_pkg::DataW-1:0] quotient
);
  import srg_pkg::*;

  localparam int unsigned CntW = $clog2(DataW);

  logic              busy_r, busy_nxt;
  logic              fin_r, fin_nxt;
  logic              done_r, done_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic [DataW-1:0]  rem_r, rem_nxt;
  logic [DataW-1:0]  quo_r, quo_nxt;
  logic [DataW-1:0]  dvs_r, dvs_nxt;
  logic [DataW-1:0]  q_r, q_nxt;
  logic [DataW:0]    rem_sh;
  logic [DataW:0]    trial;

  assign rem_sh = {rem_r, quo_r[DataW-1]};
  assign trial  = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = dividend[DataW-1] ^ divisor[DataW-1];
      rem_nxt  = '0;
      quo_nxt  = dividend[DataW-1] ? -dividend : dividend;
      dvs_nxt  = divisor[DataW-1] ? -divisor : divisor;
    end else if (busy_r) begin
      if (!trial[DataW]) begin
        rem_nxt = trial[DataW-1:0];
        quo_nxt = {quo_r[DataW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DataW-1:0];
        quo_nxt = {quo_r[DataW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CntW'(1);
      if (cnt_r == CntW'(DataW - 1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (fin_r) begin
      // sign fix in a step of its own, off the iteration path
      q_nxt    = neg_r ? -quo_r : quo_r;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
  end

  assign busy     = busy_r | fin_r;
  assign done     = done_r;
  assign quotient = q_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider did not start");

  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(fin_r))
    else $error("divider done without a finished run");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r && !fin_r)
    else $error("divider started while busy");

endmodule

FILE: hdl/srg_dp.sv
// ----------------------------------------------------------------------------
// srg_dp
// Datapath: input capture, ramp state, rate register, duration product,
// step count scaling, divider with operand select, and the output register.
// ----------------------------------------------------------------------------
module srg_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  srg_pkg::srg_cmd_t         cmd,
  output srg_pkg::srg_status_t      status,
  input  logic                      cfg_wr_en,
  input  logic [srg_pkg::RateW-1:0] cfg_wr_data,
  input  logic [srg_pkg::FuncW-1:0] in_func,
  input  logic [srg_pkg::DataW-1:0] in_target,
  input  logic [srg_pkg::DurW-1:0]  in_duration_ms,
  input  logic [srg_pkg::DataW-1:0] in_increment,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [srg_pkg::DataW-1:0] out_reference,
  output logic                      out_done_res
);
  import srg_pkg::*;

  // captured command
  func_t             func_r;
  logic [DataW-1:0]  target_r;
  logic [DurW-1:0]   dur_r;
  logic [DataW-1:0]  inc_r;
  logic [ProdW-1:0]  prod_r;
  logic [DataW-1:0]  n_r;

  // ramp state
  logic [RateW-1:0]  rate_r;
  logic [DataW-1:0]  ref_r, ref_nxt;
  logic [DataW-1:0]  goal_r, goal_nxt;
  logic [DataW-1:0]  steps_r, steps_nxt;
  logic [DataW-1:0]  slope_r, slope_nxt;

  logic              out_valid_r;
  logic [DataW-1:0]  out_ref_r;
  logic              out_done_r;

  logic [DataW-1:0]      div_a, div_b, div_q;
  logic                  div_busy, div_done;
  logic [DataW-1:0]      delta;
  logic [RecipProdW-1:0] recip_prod;

  assign delta = target_r - ref_r;

  // product / 1000 = (product >> 3) / 125 by reciprocal multiply
  assign recip_prod = {{RecipMulW{1'b0}}, prod_r[ProdW-1:RecipPreShift]}
                    * {{RecipPreW{1'b0}}, RECIP_MUL};

  always_comb begin
    case (cmd.div_sel)
      DIV_SLOPE: begin
        div_a = delta;
        div_b = steps_r;
      end
      DIV_STEP: begin
        div_a = delta;
        div_b = inc_r;
      end
      default: begin
        div_a = delta;
        div_b = inc_r;
      end
    endcase
  end

  srg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r   <= func_t'(in_func);
      target_r <= in_target;
      dur_r    <= in_duration_ms;
      inc_r    <= in_increment;
    end
    if (cmd.mul) begin
      prod_r <= {{RateW{1'b0}}, dur_r} * {{DurW{1'b0}}, rate_r};
    end
    if (cmd.recip) begin
      n_r <= {{(DataW-RecipOutW){1'b0}}, recip_prod[RecipProdW-1:RecipShift]};
    end
  end

  always_comb begin
    ref_nxt   = ref_r;
    goal_nxt  = goal_r;
    steps_nxt = steps_r;
    slope_nxt = slope_r;
    if (cmd.tick) begin
      if ($signed(steps_r) > $signed(DataW'(1))) begin
        ref_nxt   = ref_r + slope_r;
        steps_nxt = steps_r - DataW'(1);
      end else if (steps_r == DataW'(1)) begin
        ref_nxt   = goal_r;
        steps_nxt = '0;
      end
    end
    if (cmd.jump) begin
      ref_nxt   = target_r;
      goal_nxt  = target_r;
      steps_nxt = '0;
      slope_nxt = '0;
    end
    if (cmd.stop) begin
      steps_nxt = '0;
      slope_nxt = '0;
    end
    if (cmd.set_n) begin
      goal_nxt  = target_r;
      steps_nxt = n_r;
    end
    if (cmd.set_slope) begin
      slope_nxt = div_q;
    end
    if (cmd.set_step) begin
      goal_nxt  = target_r;
      steps_nxt = div_q + DataW'(1);
      slope_nxt = inc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r      <= RATE_RESET;
      ref_r       <= '0;
      goal_r      <= '0;
      steps_r     <= '0;
      slope_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        rate_r <= cfg_wr_data;
      end
      ref_r   <= ref_nxt;
      goal_r  <= goal_nxt;
      steps_r <= steps_nxt;
      slope_r <= slope_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ref_r  <= ref_r;
      out_done_r <= (steps_r == '0);
    end
  end

  assign status.func     = func_r;
  assign status.dur_zero = (dur_r == '0);
  assign status.inc_zero = (inc_r == '0);
  assign status.div_done = div_done;
  assign status.n_zero   = (n_r == '0);
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_reference = out_ref_r;
  assign out_done_res  = out_done_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r || out_ready)
    else $error("output beat overwritten before it was taken");

  a_tick_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tick && steps_r == DataW'(1)) |=> (steps_r == '0 && ref_r == $past(goal_r)))
    else $error("last tick did not land on the goal");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divide requested while divider busy");

endmodule

FILE: hdl/srg_ctrl.sv
// ----------------------------------------------------------------------------
// srg_ctrl
// Command sequencer: takes one input beat, steps through the multiply and
// divide phases a command needs, then hands the result to the output register.
// ----------------------------------------------------------------------------
module srg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  srg_pkg::srg_status_t status,
  output srg_pkg::srg_cmd_t    cmd
);
  import srg_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DECODE = 8'b0000_0010,
    ST_DIVN   = 8'b0000_0100,
    ST_WAITN  = 8'b0000_1000,
    ST_DIVS   = 8'b0001_0000,
    ST_WAITS  = 8'b0010_0000,
    ST_WAITP  = 8'b0100_0000,
    ST_FIN    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_sel = DIV_SLOPE;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status.func)
          FUNC_TICK: begin
            cmd.tick  = 1'b1;
            state_nxt = ST_FIN;
          end
          FUNC_TIMED: begin
            if (status.dur_zero) begin
              cmd.jump  = 1'b1;
              state_nxt = ST_FIN;
            end else begin
              cmd.mul   = 1'b1;
              state_nxt = ST_DIVN;
            end
          end
          FUNC_STEP: begin
            if (status.inc_zero) begin
              cmd.jump  = 1'b1;
              state_nxt = ST_FIN;
            end else begin
              cmd.div_start = 1'b1;
              cmd.div_sel   = DIV_STEP;
              state_nxt     = ST_WAITP;
            end
          end
          default: begin
            cmd.stop  = 1'b1;
            state_nxt = ST_FIN;
          end
        endcase
      end
      ST_DIVN: begin
        // step count from the duration product, scaled by 1/1000
        cmd.recip = 1'b1;
        state_nxt = ST_WAITN;
      end
      ST_WAITN: begin
        // zero step count means jump straight to the target
        if (status.n_zero) begin
          cmd.jump  = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          cmd.set_n = 1'b1;
          state_nxt = ST_DIVS;
        end
      end
      ST_DIVS: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SLOPE;
        state_nxt     = ST_WAITS;
      end
      ST_WAITS: begin
        if (status.div_done) begin
          cmd.set_slope = 1'b1;
          state_nxt     = ST_FIN;
        end
      end
      ST_WAITP: begin
        if (status.div_done) begin
          cmd.set_step = 1'b1;
          state_nxt    = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.tick, cmd.jump, cmd.stop, cmd.set_n, cmd.set_slope,
                cmd.set_step}) <= 1)
    else $error("more than one state update in a cycle");

  a_load_then_decode: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_in |=> state_r == ST_DECODE && !in_ready)
    else $error("accepted beat not decoded");

  a_fin_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> $past(state_r) == ST_FIN || $past(state_r) == ST_DECODE
                     || $past(state_r) == ST_WAITN || $past(state_r) == ST_WAITS
                     || $past(state_r) == ST_WAITP)
    else $error("result loaded without a preceding command phase");

endmodule

FILE: hdl/setpoint_ramp_generator.sv
// ----------------------------------------------------------------------------
// setpoint_ramp_generator
// Linear setpoint ramp: tick, timed start, step start and stop commands,
// one result beat per command.
//
//   channel  dir  handshake                 payload
//   in_      in   in_tvalid / in_tready     tdata: target, duration_ms, increment
//                                           tuser: func
//   out_     out  out_tvalid / out_tready   tdata: reference, done_res
//   cfg_     in   cfg_wr_en                 update_rate_hz
//
// A tick or stop goes from decode straight to the final state; a step start
// first runs one divider pass (an iteration per quotient bit, then a sign
// fix), a timed start a multiply, a scaling by 1/1000, then one divider pass
// for the slope.
// One command is in work at a time; the next beat is taken as soon as the
// previous result sits in the output register, even if not yet taken.
// A stalled output holds the sequencer in its final state until the
// register frees. Reset (rst_n low, synchronous) clears the ramp state and
// sets the tick rate to 1000 Hz.
// ----------------------------------------------------------------------------
module setpoint_ramp_generator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [79:0]               in_tdata,   // target, duration_ms, increment
  input  logic [srg_pkg::FuncW-1:0] in_tuser,   // func
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [39:0]               out_tdata,  // reference, done_res, zero pad
  input  logic                      cfg_wr_en,
  input  logic [srg_pkg::RateW-1:0] cfg_wr_data
);
  import srg_pkg::*;

  srg_cmd_t          cmd;
  srg_status_t       status;
  logic [DataW-1:0]  out_reference;
  logic              out_done_res;

  srg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  srg_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_func        (in_tuser),
    .in_target      (in_tdata[31:0]),
    .in_duration_ms (in_tdata[47:32]),
    .in_increment   (in_tdata[79:48]),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_reference  (out_reference),
    .out_done_res   (out_done_res)
  );

  assign out_tdata = {7'd0, out_done_res, out_reference};

endmodule

FILE: tb/setpoint_ramp_generator_test.sv
// ----------------------------------------------------------------------------
// setpoint_ramp_generator_test
// Self-checking bench for the setpoint ramp generator. A directed plan covers
// jumps, wrap-around, divider overflow, stalled ramps and the rate extremes.
// Random phases at several tick rates follow, mostly ramp starts then runs of
// ticks. Each result beat is checked against an in-bench ramp predictor or a
// typed plan value, with random idling on both streams but in the last phase.
// ----------------------------------------------------------------------------
module setpoint_ramp_generator_test;
  import srg_pkg::*;

  localparam logic [31:0] MAX_REF = 32'h7fff_ffff;
  localparam logic [31:0] MIN_REF = 32'h8000_0000;
  localparam int unsigned PLAN_ROWS = 26;
  localparam int unsigned PHASE_BEATS = 60;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [31:0] reference;
    logic        done;
  } setpoint_t;

  typedef struct packed {
    logic        wr_rate;
    logic [14:0] rate;
    func_t       func;
    logic [31:0] target;
    logic [15:0] duration;
    logic [31:0] increment;
    logic        typed;
    logic [31:0] typed_ref;
    logic        typed_done;
  } plan_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [79:0]       in_tdata;   // target, duration_ms, increment
  logic [FuncW-1:0]  in_tuser;   // func
  logic              out_tvalid;
  logic              out_tready;
  logic [39:0]       out_tdata;  // reference, done_res, zero pad
  logic              cfg_wr_en;
  logic [RateW-1:0]  cfg_wr_data;

  // predictor state
  logic [31:0]       ref_now;
  logic [31:0]       goal_now;
  logic [31:0]       steps_now;
  logic [31:0]       slope_now;
  logic [RateW-1:0]  rate_now;

  setpoint_t         pending_setpoints[$];
  setpoint_t         oldest_setpoint;
  int unsigned       mismatches = 0;
  logic              idle_on = 1'b1;

  plan_row_t plan [0:PLAN_ROWS-1] = '{
    '{1'b0, 15'd0, FUNC_TICK,  32'd0,    16'd0,     32'd0,        1'b1, 32'd0,   1'b1},
    '{1'b0, 15'd0, FUNC_STOP,  32'd0,    16'd0,     32'd0,        1'b1, 32'd0,   1'b1},
    '{1'b0, 15'd0, FUNC_TIMED, 32'd100,  16'd0,     32'd0,        1'b1, 32'd100, 1'b1},
    '{1'b0, 15'd0, FUNC_STEP,  MAX_REF,  16'd0,     32'd0,        1'b1, MAX_REF, 1'b1},
    // ramp that wraps over the top of the range
    '{1'b0, 15'd0, FUNC_STEP,  MIN_REF,  16'd0,     32'd1,        1'b0, 32'd0,   1'b0},
    '{1'b0, 15'd0, FUNC_TICK,  32'd0,    16'd0,     32'd0,        1'b0, 32'd0,   1'b0},
    '{1'b0, 15'd0, FUNC_TICK,  32'd0,    16'd0,     32'd0,        1'b0, 32'd0,   1'b0},
    '{1'b0, 15'd0, FUNC_TIMED, 32'd0,    16'd0,     32'd0,        1'b1, 32'd0,   1'b1},
    '{1'b0, 15'd0, FUNC_TIMED, 32'd1000, 16'd10,    32'd0,        1'b0, 32'd0,   1'b0},
    '{1'b0, 15'd0, FUNC_TICK,  32'd0,    16'd0,     32'd0,        1'b0, 32'd0,   1'b0},
    '{1'b0, 15'd0, FUNC_TICK,  32'd0,    16'd0,     32'd0,        1'b0, 32'd0,   1'b0},
    '{1'b0, 15'd0, FUNC_STOP,  32'd0,    16'd0,     32'd0,        1'b0, 32'd0,   1'b0},
    '{1'b0, 15'd0, FUNC_TICK,  32'd0,    16'd0,     32'd0,        1'b0, 32'd0,   1'b0},
    '{1'b0, 15'd0, FUNC_TIMED, MIN_REF,  16'hffff,  32'd0,        1'b0, 32'd0,   1'b0},
    '{1'b0, 15'd0, FUNC_TIMED, MIN_REF,  16'd0,     32'd0,        1'b1, MIN_REF, 1'b1},
    // most negative over minus one: count wraps negative and the ramp stalls
    '{1'b0, 15'd0, FUNC_STEP,  32'd0,    16'd0,     32'hffff_ffff, 1'b1, MIN_REF, 1'b0},
    '{1'b0, 15'd0, FUNC_TICK,  32'd0,    16'd0,     32'd0,        1'b1, MIN_REF, 1'b0},
    '{1'b0, 15'd0, FUNC_TIMED, 32'd0,    16'd0,     32'd0,        1'b1, 32'd0,   1'b1},
    // increment pointing away from the target gives a negative count
    '{1'b0, 15'd0, FUNC_STEP,  32'd10,   16'd0,     32'hffff_fffd, 1'b1, 32'd0,   1'b0},
    '{1'b0, 15'd0, FUNC_TICK,  32'd0,    16'd0,     32'd0,        1'b1, 32'd0,   1'b0},
    '{1'b0, 15'd0, FUNC_STEP,  MAX_REF,  16'd0,     MAX_REF,      1'b0, 32'd0,   1'b0},
    '{1'b1, 15'd1, FUNC_TICK,  32'd0,    16'd0,     32'd0,        1'b0, 32'd0,   1'b0},
    // duration too short for the rate: zero steps, straight to target
    '{1'b0, 15'd0, FUNC_TIMED, 32'd500,  16'd999,   32'd0,        1'b1, 32'd500, 1'b1},
    '{1'b1, 15'h7fff, FUNC_TICK, 32'd0,  16'd0,     32'd0,        1'b0, 32'd0,   1'b0},
    '{1'b0, 15'd0, FUNC_TIMED, MIN_REF,  16'hffff,  32'd0,        1'b0, 32'd0,   1'b0},
    '{1'b0, 15'd0, FUNC_STEP,  MAX_REF,  16'd0,     MIN_REF,      1'b0, 32'd0,   1'b0}
  };

  setpoint_ramp_generator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // signed division truncating toward zero, quotient wrapped to 32 bits
  function automatic logic [31:0] wrap_div(logic [31:0] num, logic [31:0] den);
    longint quot;
    quot = longint'($signed(num)) / longint'($signed(den));
    return quot[31:0];
  endfunction

  function automatic void jump_to(logic [31:0] tgt);
    ref_now   = tgt;
    goal_now  = tgt;
    steps_now = '0;
    slope_now = '0;
  endfunction

  function automatic setpoint_t ramp_advance(func_t f, logic [31:0] tgt,
                                             logic [15:0] dur, logic [31:0] inc);
    logic [31:0] n;
    setpoint_t   sp;
    case (f)
      FUNC_TICK: begin
        if ($signed(steps_now) > 1) begin
          ref_now   = ref_now + slope_now;
          steps_now = steps_now - 32'd1;
        end else if (steps_now == 32'd1) begin
          ref_now   = goal_now;
          steps_now = '0;
        end
      end
      FUNC_TIMED: begin
        n = (32'(dur) * 32'(rate_now)) / RATE_DIVISOR;
        if (dur == 16'd0 || n == 32'd0) begin
          jump_to(tgt);
        end else begin
          goal_now  = tgt;
          steps_now = n;
          slope_now = wrap_div(tgt - ref_now, n);
        end
      end
      FUNC_STEP: begin
        if (inc == 32'd0) begin
          jump_to(tgt);
        end else begin
          goal_now  = tgt;
          steps_now = wrap_div(tgt - ref_now, inc) + 32'd1;
          slope_now = inc;
        end
      end
      default: begin
        steps_now = '0;
        slope_now = '0;
      end
    endcase
    sp.reference = ref_now;
    sp.done      = (steps_now == 32'd0);
    return sp;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // result side back-pressure
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_setpoints.size() == 0) begin
        $display("%0t: result beat with nothing pending, got reference %h done %b",
                 $time, out_tdata[31:0], out_tdata[32]);
        mismatches++;
      end else begin
        oldest_setpoint = pending_setpoints.pop_front();
        if (out_tdata[31:0] !== oldest_setpoint.reference) begin
          $display("%0t: reference expected %h actual %h",
                   $time, oldest_setpoint.reference, out_tdata[31:0]);
          mismatches++;
        end
        if (out_tdata[32] !== oldest_setpoint.done) begin
          $display("%0t: done_res expected %b actual %b",
                   $time, oldest_setpoint.done, out_tdata[32]);
          mismatches++;
        end
      end
    end
  end

  task automatic send_command(func_t f, logic [31:0] tgt, logic [15:0] dur,
                              logic [31:0] inc);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {inc, dur, tgt};
    do @(posedge clk); while (!in_tready);
    pending_setpoints.push_back(ramp_advance(f, tgt, dur, inc));
  endtask

  // rate changes only once every pending result has come back
  task automatic write_rate(logic [RateW-1:0] rate);
    in_tvalid <= 1'b0;
    while (pending_setpoints.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rate;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    rate_now = rate;
  endtask

  task automatic ramp_phase(int unsigned beats);
    int unsigned sent;
    int unsigned ticks;
    int unsigned k;
    int          offset;
    logic [31:0] tgt;
    logic [31:0] inc;
    logic [15:0] dur;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(0, 4) == 0) begin
        // noise: any command, any content
        send_command(func_t'($urandom_range(0, 3)), $urandom,
                     16'($urandom_range(0, 65535)), $urandom);
        sent++;
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          k = $urandom_range(0, 20);
          if ($urandom_range(0, 9) == 0) begin
            dur = 16'($urandom_range(0, 65535));
          end else if ((k * 1000 + rate_now - 1) / rate_now > 65535) begin
            dur = 16'hffff;
          end else begin
            dur = 16'((k * 1000 + rate_now - 1) / rate_now);
          end
          offset = int'($urandom_range(0, 4000)) - 2000;
          tgt = ($urandom_range(0, 1) == 0) ? $urandom : ref_now + 32'(offset);
          send_command(FUNC_TIMED, tgt, dur, $urandom);
        end else begin
          if ($urandom_range(0, 3) == 0) begin
            inc = $urandom;
          end else begin
            offset = int'($urandom_range(0, 200)) - 100;
            inc = 32'(offset);
          end
          tgt = ($urandom_range(0, 3) == 0) ? $urandom
                : ref_now + inc * 32'($urandom_range(0, 15));
          send_command(FUNC_STEP, tgt, 16'($urandom_range(0, 65535)), inc);
        end
        ticks = $urandom_range(1, 24);
        repeat (ticks) begin
          send_command(($urandom_range(0, 29) == 0) ? FUNC_STOP : FUNC_TICK,
                       $urandom, 16'($urandom_range(0, 65535)), $urandom);
        end
        sent += 1 + ticks;
      end
    end
  endtask

  initial begin
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= FUNC_TICK;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    rst_n       <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    ref_now   = '0;
    goal_now  = '0;
    steps_now = '0;
    slope_now = '0;
    rate_now  = RATE_RESET;
    @(posedge clk);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].wr_rate) begin
        write_rate(plan[i].rate);
      end else begin
        send_command(plan[i].func, plan[i].target, plan[i].duration, plan[i].increment);
        if (plan[i].typed) begin
          void'(pending_setpoints.pop_back());
          pending_setpoints.push_back('{plan[i].typed_ref, plan[i].typed_done});
        end
      end
    end

    write_rate(RATE_RESET);
    ramp_phase(PHASE_BEATS);
    write_rate(15'd1);
    ramp_phase(PHASE_BEATS);
    write_rate(15'h7fff);
    ramp_phase(PHASE_BEATS);
    write_rate(15'($urandom_range(1, 32767)));
    ramp_phase(PHASE_BEATS);
    write_rate(15'($urandom_range(1, 2000)));
    ramp_phase(PHASE_BEATS);
    // closing stretch runs flat out on both sides
    write_rate(15'($urandom_range(1, 32767)));
    idle_on = 1'b0;
    ramp_phase(PHASE_BEATS);

    in_tvalid <= 1'b0;
    while (pending_setpoints.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
